// ----- hdl/tanbt_pkg.sv -----
// Package: shared types, constants and state encoding for the tangent/bitangent unit.
`default_nettype none
package tanbt_pkg;

   localparam int COORD_W  = 32;
   localparam int WIDE_W   = 64;
   localparam int Q_W      = 16;
   localparam int QUOT_W   = 15;
   localparam int MUL_LAST = 14;
   localparam int SQRT_LAST = 31;
   localparam int DIV_LAST = 14;
   localparam int SQ_LAST  = 2;
   localparam logic [QUOT_W-1:0] Q14_ONE = 15'd16384;
   localparam int FIFO_DEPTH = 2;

   typedef logic signed [COORD_W-1:0] coord_type;

   // one triangle after delta forming and range fitting
   typedef struct packed {
      coord_type [5:0] e;   // e1 xyz in [2:0], e2 xyz in [5:3]
      coord_type [3:0] d;   // d1.u, d1.v, d2.u, d2.v
   } tri_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_LOAD,
      ST_NORM,
      ST_SQ,
      ST_SQRT,
      ST_DIV,
      ST_OUT
   } back_state_type;

endpackage : tanbt_pkg
`default_nettype wire

// ----- hdl/tanbt_front.sv -----
// Front end: holds the first two corners and forms fitted edges and UV deltas.
`default_nettype none
module tanbt_front
   import tanbt_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   output logic                req_tready,
   input  wire logic [159:0]   req_tdata,   // pos_x, pos_y, pos_z, tex_u, tex_v
   output logic                push_valid,
   input  wire logic           push_ready,
   output tri_type             push_data
);

   logic [1:0]  count_ff, count_in;
   coord_type   px_ff [2], py_ff [2], pz_ff [2], u_ff [2], v_ff [2];
   coord_type   px, py, pz, u, v;
   logic        third, accept;
   logic signed [COORD_W:0] e_w [6];
   logic signed [COORD_W:0] d_w [4];
   logic        e_big, d_big;

   assign px = req_tdata[31:0];
   assign py = req_tdata[63:32];
   assign pz = req_tdata[95:64];
   assign u  = req_tdata[127:96];
   assign v  = req_tdata[159:128];

   // counts of two or three both mean the closing corner
   assign third      = count_ff[1];
   assign req_tready = !third || push_ready;
   assign accept     = req_tvalid && req_tready;
   assign push_valid = req_tvalid && third;

   always_comb begin
      e_w[0] = {px_ff[1][31], px_ff[1]} - {px_ff[0][31], px_ff[0]};
      e_w[1] = {py_ff[1][31], py_ff[1]} - {py_ff[0][31], py_ff[0]};
      e_w[2] = {pz_ff[1][31], pz_ff[1]} - {pz_ff[0][31], pz_ff[0]};
      e_w[3] = {px[31], px} - {px_ff[0][31], px_ff[0]};
      e_w[4] = {py[31], py} - {py_ff[0][31], py_ff[0]};
      e_w[5] = {pz[31], pz} - {pz_ff[0][31], pz_ff[0]};
      d_w[0] = {u_ff[1][31], u_ff[1]} - {u_ff[0][31], u_ff[0]};
      d_w[1] = {v_ff[1][31], v_ff[1]} - {v_ff[0][31], v_ff[0]};
      d_w[2] = {u[31], u} - {u_ff[0][31], u_ff[0]};
      d_w[3] = {v[31], v} - {v_ff[0][31], v_ff[0]};
      e_big = 1'b0;
      d_big = 1'b0;
      for (int i = 0; i < 6; i++) begin
         e_big = e_big || (e_w[i][32] != e_w[i][31]);
      end
      for (int i = 0; i < 4; i++) begin
         d_big = d_big || (d_w[i][32] != d_w[i][31]);
      end
      // halve the whole group (floor) when any member leaves 32 bits
      for (int i = 0; i < 6; i++) begin
         push_data.e[i] = e_big ? e_w[i][32:1] : e_w[i][31:0];
      end
      for (int i = 0; i < 4; i++) begin
         push_data.d[i] = d_big ? d_w[i][32:1] : d_w[i][31:0];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         count_in = third ? 2'd0 : count_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !third) begin
         px_ff[count_ff[0]] <= px;
         py_ff[count_ff[0]] <= py;
         pz_ff[count_ff[0]] <= pz;
         u_ff[count_ff[0]]  <= u;
         v_ff[count_ff[0]]  <= v;
      end
   end

endmodule : tanbt_front
`default_nettype wire

// ----- hdl/tanbt_fifo.sv -----
// Two-entry triangle queue between the front end and the back end.
`default_nettype none
module tanbt_fifo
   import tanbt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   output logic         push_ready,
   input  wire tri_type push_data,
   output logic         pop_valid,
   input  wire logic    pop_ready,
   output tri_type      pop_data
);

   tri_type     mem_ff [FIFO_DEPTH];
   logic        wr_ff, rd_ff;
   logic [1:0]  fill_ff;
   logic        push, pop;

   assign push_ready = (fill_ff != 2'(FIFO_DEPTH));
   assign pop_valid  = (fill_ff != 2'd0);
   assign pop_data   = mem_ff[rd_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= 1'b0;
         rd_ff   <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop)  rd_ff <= !rd_ff;
         fill_ff <= fill_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule : tanbt_fifo
`default_nettype wire

// ----- hdl/tanbt_back.sv -----
// Back end: products, normalization, square root and division for one triangle.
`default_nettype none
module tanbt_back
   import tanbt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    pop_valid,
   output logic         pop_ready,
   input  wire tri_type pop_data,
   output logic         rsp_tvalid,
   input  wire logic    rsp_tready,
   output logic [95:0]  rsp_tdata,
   output logic         rsp_tuser
);

   back_state_type state_ff, state_in;
   tri_type              tri_ff;
   logic [5:0]           cnt_ff;
   logic [1:0]           comp_ff;
   logic                 vec_ff;
   logic signed [WIDE_W-1:0] prod_ff, acc_ff;
   logic signed [WIDE_W-1:0] rs_ff [7];   // det, T xyz, B xyz
   logic [WIDE_W-1:0]    m_ff [3];
   logic [WIDE_W-1:0]    mx_ff;
   logic [2:0]           neg_ff;
   logic [WIDE_W-1:0]    sq_ff, n_ff, res_ff, bit_ff;
   logic [32:0]          rem_ff;
   logic [QUOT_W-1:0]    q_ff;
   logic signed [Q_W-1:0] qv_ff [2][3];
   logic                 degen_ff;
   logic                 out_valid_ff;
   logic [95:0]          out_data_ff;
   logic                 out_user_ff;

   logic signed [COORD_W-1:0] mul_a, mul_b;
   logic signed [WIDE_W-1:0]  mul_p;
   logic [3:0]           kk;
   logic                 det_zero, det_neg, out_free;
   logic [WIDE_W-1:0]    ld_m [3];
   logic [2:0]           ld_neg;
   logic [WIDE_W-1:0]    ld_mx;
   logic                 norm_hi, norm_lo;
   logic [59:0]          sq_term;
   logic [WIDE_W-1:0]    sqrt_t;
   logic [31:0]          root;
   logic [44:0]          num;
   logic [5:0]           div_idx;
   logic [32:0]          rem_base, trial;
   logic                 ge;
   logic [QUOT_W-1:0]    q_fin, q_sat;
   logic                 div_end;

   assign det_zero = (rs_ff[0] == '0);
   assign det_neg  = rs_ff[0][WIDE_W-1];
   assign out_free = !out_valid_ff || rsp_tready;
   assign kk       = cnt_ff[3:0];

   // operand schedule: even step loads the accumulator, odd step subtracts
   always_comb begin
      case (kk)
         4'd0:    begin mul_a = tri_ff.d[0]; mul_b = tri_ff.d[3]; end
         4'd1:    begin mul_a = tri_ff.d[1]; mul_b = tri_ff.d[2]; end
         4'd2:    begin mul_a = tri_ff.d[3]; mul_b = tri_ff.e[0]; end
         4'd3:    begin mul_a = tri_ff.d[1]; mul_b = tri_ff.e[3]; end
         4'd4:    begin mul_a = tri_ff.d[3]; mul_b = tri_ff.e[1]; end
         4'd5:    begin mul_a = tri_ff.d[1]; mul_b = tri_ff.e[4]; end
         4'd6:    begin mul_a = tri_ff.d[3]; mul_b = tri_ff.e[2]; end
         4'd7:    begin mul_a = tri_ff.d[1]; mul_b = tri_ff.e[5]; end
         4'd8:    begin mul_a = tri_ff.d[0]; mul_b = tri_ff.e[3]; end
         4'd9:    begin mul_a = tri_ff.d[2]; mul_b = tri_ff.e[0]; end
         4'd10:   begin mul_a = tri_ff.d[0]; mul_b = tri_ff.e[4]; end
         4'd11:   begin mul_a = tri_ff.d[2]; mul_b = tri_ff.e[1]; end
         4'd12:   begin mul_a = tri_ff.d[0]; mul_b = tri_ff.e[5]; end
         4'd13:   begin mul_a = tri_ff.d[2]; mul_b = tri_ff.e[2]; end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // sign/magnitude of the vector being normalized
   always_comb begin
      ld_mx = '0;
      for (int i = 0; i < 3; i++) begin
         logic signed [WIDE_W-1:0] c;
         c = vec_ff ? rs_ff[4+i] : rs_ff[1+i];
         ld_m[i]   = c[WIDE_W-1] ? WIDE_W'(-c) : WIDE_W'(c);
         ld_neg[i] = c[WIDE_W-1] ^ det_neg;
         if (ld_m[i] > ld_mx) ld_mx = ld_m[i];
      end
   end

   assign norm_hi = (mx_ff[WIDE_W-1:30] != '0);
   assign norm_lo = !mx_ff[29];
   assign sq_term = m_ff[cnt_ff[1:0]][29:0] * m_ff[cnt_ff[1:0]][29:0];
   assign sqrt_t  = res_ff + bit_ff;
   assign root    = res_ff[31:0];

   assign num      = {1'b0, m_ff[comp_ff][29:0], 14'd0} + 45'(root >> 1);
   assign div_idx  = 6'(DIV_LAST) - cnt_ff;
   assign rem_base = (cnt_ff == 6'd0) ? 33'(num >> QUOT_W) : rem_ff;
   assign trial    = {rem_base[31:0], num[div_idx]};
   assign ge       = (trial >= {1'b0, root});
   assign q_fin    = {q_ff[QUOT_W-2:0], ge};
   assign q_sat    = (q_fin > Q14_ONE) ? Q14_ONE : q_fin;
   assign div_end  = (cnt_ff == 6'(DIV_LAST));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (pop_valid) state_in = ST_MUL;
         ST_MUL:  if (cnt_ff == 6'(MUL_LAST)) state_in = ST_LOAD;
         ST_LOAD: begin
            if (det_zero || ld_mx == '0) state_in = ST_OUT;
            else state_in = ST_NORM;
         end
         ST_NORM: if (!norm_hi && !norm_lo) state_in = ST_SQ;
         ST_SQ:   if (cnt_ff == 6'(SQ_LAST)) state_in = ST_SQRT;
         ST_SQRT: if (cnt_ff == 6'(SQRT_LAST)) state_in = ST_DIV;
         ST_DIV: begin
            if (div_end && comp_ff == 2'd2) state_in = vec_ff ? ST_OUT : ST_LOAD;
         end
         ST_OUT:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      pop_ready = (state_ff == ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_OUT && out_free) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_in != state_ff) begin
         cnt_ff <= '0;
      end else if (state_ff == ST_DIV && div_end) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_ff + 6'd1;
      end

      case (state_ff)
         ST_IDLE: begin
            tri_ff   <= pop_data;
            vec_ff   <= 1'b0;
            degen_ff <= 1'b0;
         end
         ST_MUL: begin
            prod_ff <= mul_p;
            if (cnt_ff != 6'd0) begin
               if (cnt_ff[0]) acc_ff <= prod_ff;
               else rs_ff[cnt_ff[3:1] - 3'd1] <= acc_ff - prod_ff;
            end
         end
         ST_LOAD: begin
            m_ff     <= ld_m;
            mx_ff    <= ld_mx;
            neg_ff   <= ld_neg;
            sq_ff    <= '0;
            comp_ff  <= 2'd0;
            degen_ff <= det_zero || (ld_mx == '0);
         end
         ST_NORM: begin
            for (int i = 0; i < 3; i++) begin
               if (norm_hi) m_ff[i] <= m_ff[i] >> 1;
               else if (norm_lo) m_ff[i] <= m_ff[i] << 1;
            end
            if (norm_hi) mx_ff <= mx_ff >> 1;
            else if (norm_lo) mx_ff <= mx_ff << 1;
         end
         ST_SQ: begin
            sq_ff  <= sq_ff + WIDE_W'(sq_term);
            n_ff   <= '0;
            res_ff <= '0;
            bit_ff <= WIDE_W'(1) << 62;
         end
         ST_SQRT: begin
            if (cnt_ff == 6'd0) begin
               // first step starts from the sum of squares
               if (sq_ff >= sqrt_t) begin
                  n_ff   <= sq_ff - sqrt_t;
                  res_ff <= (res_ff >> 1) + bit_ff;
               end else begin
                  n_ff   <= sq_ff;
                  res_ff <= res_ff >> 1;
               end
            end else if (n_ff >= sqrt_t) begin
               n_ff   <= n_ff - sqrt_t;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         ST_DIV: begin
            rem_ff <= ge ? trial - {1'b0, root} : trial;
            q_ff   <= q_fin;
            if (div_end) begin
               qv_ff[vec_ff][comp_ff] <= neg_ff[comp_ff] ? -Q_W'(q_sat) : Q_W'(q_sat);
               comp_ff <= comp_ff + 2'd1;
               if (comp_ff == 2'd2) vec_ff <= 1'b1;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               out_user_ff <= degen_ff;
               out_data_ff <= degen_ff ? '0 :
                  {qv_ff[1][2], qv_ff[1][1], qv_ff[1][0],
                   qv_ff[0][2], qv_ff[0][1], qv_ff[0][0]};
            end
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

endmodule : tanbt_back
`default_nettype wire

// ----- hdl/triangle_tangent_bitangent.sv -----
// Top level: per-triangle unit tangent and bitangent from a vertex stream.
//
//  channel | direction | payload
//  req_    | in        | tdata: pos_x, pos_y, pos_z, tex_u, tex_v (Q16.16)
//  rsp_    | out       | tdata: tan xyz, bitan xyz (Q1.14); tuser: degenerate
//
// The first two vertices of a triangle are taken one per cycle. The closing
// vertex goes to a two-deep queue; the back end takes one triangle at a time (15
// product steps, up to 34 shift steps, 3 squares, 32 root steps and 45 divide
// steps per vector) on a shared product multiplier, a square multiplier and root
// and divide loops. Synchronous reset clears the sequencer, corner count, queue
// and output valid. A stalled result holds in its register while the next triangle runs.
`default_nettype none
module triangle_tangent_bitangent
   import tanbt_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   output logic                req_tready,
   input  wire logic [159:0]   req_tdata,  // pos_x, pos_y, pos_z, tex_u, tex_v
   output logic                rsp_tvalid,
   input  wire logic           rsp_tready,
   output logic [95:0]         rsp_tdata,  // tan_x, tan_y, tan_z, bitan_x, bitan_y, bitan_z
   output logic                rsp_tuser   // degenerate
);

   logic    push_valid, push_ready, pop_valid, pop_ready;
   tri_type push_data, pop_data;

   tanbt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   tanbt_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   tanbt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule : triangle_tangent_bitangent
`default_nettype wire

// ----- hdl/tanbt_checker.sv -----
// Port checker for the tangent/bitangent unit, bound to the top level.
`default_nettype none
module tanbt_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [95:0]  rsp_tdata,
   input wire logic         rsp_tuser
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 96'd0)
      else $error("degenerate result carries nonzero vectors");

   // a unit vector always has a large component
   a_unit_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[47:0] != 48'd0 && rsp_tdata[95:48] != 48'd0)
      else $error("regular result has a zero vector");

   // after reset no result is pending and the first corner is taken at once
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid && req_tready)
      else $error("not idle right after reset");

endmodule : tanbt_checker

bind triangle_tangent_bitangent tanbt_checker u_tanbt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
